### hw/rtl/pre_pkg.sv
// Shared types and constants for the printable run extractor.
// Used by every module of the block but pre_ram; depends on nothing.
package pre_pkg;

    localparam int CNT_W     = 6;   // run length counts and threshold
    localparam int CFG_W     = 6;   // min_run_length register
    localparam int BYTE_W    = 8;
    localparam int CMD_DEPTH = 2;   // front-to-back command queue
    localparam int OUT_DEPTH = 4;   // result queue in the back end

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] PRINT_LO     = 8'h20;
    localparam logic [BYTE_W-1:0] PRINT_HI     = 8'h7E;

    // Register index, taken from paddr[2] (word address)
    localparam logic              IDX_MIN_RUN_LENGTH = 1'b0;
    localparam logic [CFG_W-1:0]  MIN_RUN_RESET      = 6'd2;

    // Work for the back end caused by one accepted byte
    typedef struct packed {
        logic [CNT_W-1:0]  flush_cnt;   // held bytes to replay first
        logic              has_byte;    // then the current byte
        logic [BYTE_W-1:0] data;
        logic              has_nl;      // then a closing newline
    } cmd_t;

    // Effective threshold: zero acts as one, saturate at max_thr
    function automatic logic [CNT_W-1:0] clamp_threshold(
        input logic [CFG_W-1:0] m,
        input logic [CNT_W-1:0] max_thr
    );
        logic [CNT_W-1:0] t;
        begin
            t = m;
            if (t == '0)
            begin
                t = CNT_W'(1);
            end
            if (t > max_thr)
            begin
                t = max_thr;
            end
            return t;
        end
    endfunction

endpackage

### hw/rtl/pre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module pre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/pre_front.sv
// Front end: accepts bytes, classifies them and tracks the run state.
// Holds short-run bytes in the pending store; depends on pre_pkg.
module pre_front #(
    parameter int MAX_RUN_THRESHOLD = 32,
    parameter int STORE_DEPTH       = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             push,
    output logic                             full,
    input  logic [pre_pkg::BYTE_W-1:0]       data_byte,
    input  logic                             end_of_stream,
    // configuration
    input  logic [pre_pkg::CFG_W-1:0]        min_run_length,
    // command queue
    input  logic                             cmd_full,
    output logic                             cmd_push,
    output pre_pkg::cmd_t                    cmd,
    input  logic                             flush_done,
    // pending store write port
    output logic                             st_we,
    output logic [$clog2(STORE_DEPTH)-1:0]   st_waddr,
    output logic [pre_pkg::BYTE_W-1:0]       st_wdata
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    logic [pre_pkg::CNT_W-1:0] run_count_reg, run_count_next;
    logic                      emitting_reg, emitting_next;
    logic                      flush_wait_reg, flush_wait_next;
    logic [pre_pkg::CNT_W-1:0] thr;
    logic                      printable;
    logic                      accept;

    assign thr       = pre_pkg::clamp_threshold(min_run_length,
                                                pre_pkg::CNT_W'(MAX_RUN_THRESHOLD));
    assign printable = (data_byte >= pre_pkg::PRINT_LO) && (data_byte <= pre_pkg::PRINT_HI);

    // Hold off while a flush still reads the store or the queue is full
    assign full   = cmd_full || flush_wait_reg;
    assign accept = push && !full;

    assign st_waddr = run_count_reg[ADDR_W-1:0];
    assign st_wdata = data_byte;

    // Classify the byte and build the back-end command
    always_comb
    begin
        run_count_next = run_count_reg;
        emitting_next  = emitting_reg;
        cmd            = '0;
        cmd.data       = data_byte;
        st_we          = 1'b0;
        if (accept)
        begin
            if (printable)
            begin
                if (emitting_reg)
                begin
                    cmd.has_byte = 1'b1;
                end
                else if (({1'b0, run_count_reg} + 7'd1) >= {1'b0, thr})
                begin
                    cmd.flush_cnt  = run_count_reg;
                    cmd.has_byte   = 1'b1;
                    run_count_next = '0;
                    emitting_next  = 1'b1;
                end
                else
                begin
                    st_we          = run_count_reg < pre_pkg::CNT_W'(STORE_DEPTH);
                    run_count_next = run_count_reg + pre_pkg::CNT_W'(1);
                end
            end
            else
            begin
                cmd.has_nl     = emitting_reg;
                emitting_next  = 1'b0;
                run_count_next = '0;
            end
            // stream end: close an open run, drop a short one
            if (end_of_stream)
            begin
                if (emitting_next)
                begin
                    cmd.has_nl = 1'b1;
                end
                emitting_next  = 1'b0;
                run_count_next = '0;
            end
        end
    end

    assign cmd_push = accept && (cmd.has_byte || cmd.has_nl);

    // Flush interlock
    always_comb
    begin
        flush_wait_next = flush_wait_reg;
        if (cmd_push && (cmd.flush_cnt != '0))
        begin
            flush_wait_next = 1'b1;
        end
        else if (flush_done)
        begin
            flush_wait_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg  <= '0;
            emitting_reg   <= 1'b0;
            flush_wait_reg <= 1'b0;
        end
        else
        begin
            run_count_reg  <= run_count_next;
            emitting_reg   <= emitting_next;
            flush_wait_reg <= flush_wait_next;
        end
    end

    // A held run never reaches the largest threshold
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg < pre_pkg::CNT_W'(MAX_RUN_THRESHOLD))
        else $error("run count beyond threshold range");

    // Nothing is held while a run is being emitted
    a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        emitting_reg |-> (run_count_reg == '0))
        else $error("bytes held during emitted run");

    // Store is never written while a flush may still read it
    a_store_lock: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> !flush_wait_reg)
        else $error("store write during flush");

endmodule

### hw/rtl/pre_cmd_queue.sv
// Short command queue between the front and back ends.
// Carries pre_pkg::cmd_t; depends on pre_pkg.
module pre_cmd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pre_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output pre_pkg::cmd_t cmd_out
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pre_pkg::cmd_t   mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cmd_out = mem_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

### hw/rtl/pre_back.sv
// Back end: expands commands into result beats (held bytes, byte, newline).
// Reads the pending store and feeds the result queue; depends on pre_pkg.
module pre_back #(
    parameter int STORE_DEPTH = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // command queue
    input  logic                             cmd_empty,
    input  pre_pkg::cmd_t                    cmd,
    output logic                             cmd_pop,
    // pending store read port
    output logic                             st_re,
    output logic [$clog2(STORE_DEPTH)-1:0]   st_raddr,
    input  logic [pre_pkg::BYTE_W-1:0]       st_rdata,
    output logic                             flush_done,
    // result beats
    output logic                             empty,
    input  logic                             pop,
    output logic [pre_pkg::BYTE_W-1:0]       out_byte,
    output logic                             last_of_burst
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int OQ_AW  = $clog2(pre_pkg::OUT_DEPTH);
    localparam int OQ_CW  = $clog2(pre_pkg::OUT_DEPTH + 1);

    // Current command
    logic [pre_pkg::CNT_W-1:0]  flush_left_reg, flush_left_next;
    logic [ADDR_W-1:0]          flush_idx_reg, flush_idx_next;
    logic                       has_byte_reg, has_byte_next;
    logic [pre_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       has_nl_reg, has_nl_next;
    // Read stage (aligned with store read latency)
    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_from_store_reg, s1_from_store_next;
    logic [pre_pkg::BYTE_W-1:0] s1_byte_reg, s1_byte_next;
    logic                       s1_last_reg, s1_last_next;
    // Result queue
    logic [pre_pkg::BYTE_W-1:0] oq_byte_reg [pre_pkg::OUT_DEPTH];
    logic                       oq_last_reg [pre_pkg::OUT_DEPTH];
    logic [OQ_AW-1:0]           oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0]           oq_count_reg;

    logic active, next_active, room, issue, oq_pop;

    assign active = (flush_left_reg != '0) || has_byte_reg || has_nl_reg;
    // Reserve a slot for the beat already in the read stage
    assign room   = ({1'b0, oq_count_reg} + {{OQ_CW{1'b0}}, s1_valid_reg})
                    < (OQ_CW + 1)'(pre_pkg::OUT_DEPTH);
    assign issue  = active && room;
    assign st_raddr = flush_idx_reg;

    // Sequencer: a beat per cycle if room; next command without a bubble
    always_comb
    begin
        flush_left_next    = flush_left_reg;
        flush_idx_next     = flush_idx_reg;
        has_byte_next      = has_byte_reg;
        byte_next          = byte_reg;
        has_nl_next        = has_nl_reg;
        s1_valid_next      = issue;
        s1_from_store_next = 1'b0;
        s1_byte_next       = byte_reg;
        s1_last_next       = 1'b0;
        st_re              = 1'b0;
        flush_done         = 1'b0;
        cmd_pop            = 1'b0;
        if (issue)
        begin
            if (flush_left_reg != '0)
            begin
                st_re              = 1'b1;
                s1_from_store_next = 1'b1;
                s1_last_next       = (flush_left_reg == pre_pkg::CNT_W'(1))
                                     && !has_byte_reg && !has_nl_reg;
                flush_done         = flush_left_reg == pre_pkg::CNT_W'(1);
                flush_left_next    = flush_left_reg - pre_pkg::CNT_W'(1);
                flush_idx_next     = flush_idx_reg + ADDR_W'(1);
            end
            else if (has_byte_reg)
            begin
                s1_last_next  = !has_nl_reg;
                has_byte_next = 1'b0;
            end
            else
            begin
                s1_byte_next = pre_pkg::NEWLINE_BYTE;
                s1_last_next = 1'b1;
                has_nl_next  = 1'b0;
            end
        end
        next_active = (flush_left_next != '0) || has_byte_next || has_nl_next;
        if (!next_active && !cmd_empty)
        begin
            cmd_pop         = 1'b1;
            flush_left_next = cmd.flush_cnt;
            flush_idx_next  = '0;
            has_byte_next   = cmd.has_byte;
            byte_next       = cmd.data;
            has_nl_next     = cmd.has_nl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_left_reg <= '0;
            has_byte_reg   <= 1'b0;
            has_nl_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            flush_left_reg <= flush_left_next;
            has_byte_reg   <= has_byte_next;
            has_nl_reg     <= has_nl_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        flush_idx_reg     <= flush_idx_next;
        byte_reg          <= byte_next;
        s1_from_store_reg <= s1_from_store_next;
        s1_byte_reg       <= s1_byte_next;
        s1_last_reg       <= s1_last_next;
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            oq_byte_reg[oq_wr_reg] <= s1_from_store_reg ? st_rdata : s1_byte_reg;
            oq_last_reg[oq_wr_reg] <= s1_last_reg;
        end
    end

    assign oq_pop = pop && !empty;

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            if (s1_valid_reg)
            begin
                oq_wr_reg <= (oq_wr_reg == OQ_AW'(pre_pkg::OUT_DEPTH - 1))
                             ? '0 : oq_wr_reg + OQ_AW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= (oq_rd_reg == OQ_AW'(pre_pkg::OUT_DEPTH - 1))
                             ? '0 : oq_rd_reg + OQ_AW'(1);
            end
            if (s1_valid_reg && !oq_pop)
            begin
                oq_count_reg <= oq_count_reg + OQ_CW'(1);
            end
            else if (oq_pop && !s1_valid_reg)
            begin
                oq_count_reg <= oq_count_reg - OQ_CW'(1);
            end
        end
    end

    assign empty         = oq_count_reg == '0;
    assign out_byte      = oq_byte_reg[oq_rd_reg];
    assign last_of_burst = oq_last_reg[oq_rd_reg];

    // A store read always lands in the read stage
    a_read_align: assert property (@(posedge clk) disable iff (!rst_n)
        st_re |=> (s1_valid_reg && s1_from_store_reg))
        else $error("store read not captured");

    // Result queue never overflows
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= OQ_CW'(pre_pkg::OUT_DEPTH))
        else $error("result queue overflow");

    // Flush completes only on a store read
    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        flush_done |-> st_re)
        else $error("flush done without store read");

endmodule

### hw/rtl/printable_run_extractor_core.sv
// Top level of the printable run extractor: config register, front end,
// command queue, back end and pending store. Depends on pre_pkg.
//
// Scans a byte stream and passes on every run of printable bytes (0x20..0x7E)
// at least min_run_length long (0 acts as 1, values above MAX_RUN_THRESHOLD
// saturate), each run closed by 0x0A. Input is a queue-style push/full port,
// results leave through an empty/pop port with last_of_burst marking the
// final beat caused by one input byte. Bytes are accepted at one per cycle
// while full is low. The byte that lets a run reach the threshold replays
// the held bytes from the pending store, one store read per cycle while the
// result queue has room, and the input stalls until the last store read has
// issued. Results leave at up to one beat per cycle. Register 0
// (min_run_length, reset 2) sits at byte address 0 and should be written
// only while the block is idle.
module printable_run_extractor_core #(
    parameter int MAX_RUN_THRESHOLD = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input beats
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        end_of_stream,
    // result beats
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_burst
);

    localparam int STORE_DEPTH = (MAX_RUN_THRESHOLD > 2) ? MAX_RUN_THRESHOLD - 1 : 2;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic [pre_pkg::CFG_W-1:0]  min_run_length_reg;
    logic                       cfg_hit;

    logic                       cmd_push, cmd_full, cmd_pop, cmd_empty;
    pre_pkg::cmd_t              cmd_in, cmd_head;
    logic                       flush_done;
    logic                       st_we, st_re;
    logic [ADDR_W-1:0]          st_waddr, st_raddr;
    logic [pre_pkg::BYTE_W-1:0] st_wdata, st_rdata;

    // Configuration register
    assign pready  = 1'b1;
    assign cfg_hit = paddr[2] == pre_pkg::IDX_MIN_RUN_LENGTH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_length_reg <= pre_pkg::MIN_RUN_RESET;
        end
        else if (psel && penable && pwrite && pready && cfg_hit)
        begin
            min_run_length_reg <= pwdata[pre_pkg::CFG_W-1:0];
        end
    end

    assign prdata = cfg_hit ? {{(32 - pre_pkg::CFG_W){1'b0}}, min_run_length_reg} : '0;

    // Front end
    pre_front #(
        .MAX_RUN_THRESHOLD (MAX_RUN_THRESHOLD),
        .STORE_DEPTH       (STORE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .end_of_stream  (end_of_stream),
        .min_run_length (min_run_length_reg),
        .cmd_full       (cmd_full),
        .cmd_push       (cmd_push),
        .cmd            (cmd_in),
        .flush_done     (flush_done),
        .st_we          (st_we),
        .st_waddr       (st_waddr),
        .st_wdata       (st_wdata)
    );

    // Command queue
    pre_cmd_queue #(
        .DEPTH (pre_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .empty   (cmd_empty),
        .cmd_out (cmd_head)
    );

    // Pending store
    pre_ram #(
        .WIDTH (pre_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Back end
    pre_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_empty     (cmd_empty),
        .cmd           (cmd_head),
        .cmd_pop       (cmd_pop),
        .st_re         (st_re),
        .st_raddr      (st_raddr),
        .st_rdata      (st_rdata),
        .flush_done    (flush_done),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last_of_burst (last_of_burst)
    );

endmodule

### dv/tb.sv
// Self-checking testbench for printable_run_extractor_core: directed and random byte streams
// checked against a built-in run-extraction predictor. Depends on pre_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_THR      = 32;
    localparam int HELD_DEPTH   = 31;
    localparam int DRAIN_CYCLES = 48;   // longest replay burst plus queue depth
    localparam int IDLE_PCT     = 19;
    localparam int RANDOM_ITEMS = 460;
    localparam logic [2:0] ADDR_MIN_RUN_LENGTH = {pre_pkg::IDX_MIN_RUN_LENGTH, 2'b00};

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } beat_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        end_of_stream;
    logic        empty;
    logic        pop;
    logic [7:0]  out_byte;
    logic        last_of_burst;

    // Predictor state
    logic [5:0]  cfg_min_len;
    logic [5:0]  held_count;
    logic [7:0]  held_bytes [HELD_DEPTH];
    logic        in_run;
    beat_t       expected_beats [$];
    beat_t       staged_beat;
    bit          staged_valid;

    int          err_cnt;
    bit          steady;

    printable_run_extractor_core #(
        .MAX_RUN_THRESHOLD (MAX_THR)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .out_byte      (out_byte),
        .last_of_burst (last_of_burst)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Effective threshold: zero acts as one, large values saturate
    function automatic int unsigned eff_threshold(input logic [5:0] m);
        int unsigned t;
        begin
            t = m;
            if (t == 0)
            begin
                t = 1;
            end
            if (t > MAX_THR)
            begin
                t = MAX_THR;
            end
            return t;
        end
    endfunction

    // Holds one beat back so the final beat of a burst can be marked last
    function automatic void stage_beat(input logic [7:0] b);
        begin
            if (staged_valid)
            begin
                expected_beats.push_back(staged_beat);
            end
            staged_beat  = '{value: b, last: 1'b0};
            staged_valid = 1'b1;
        end
    endfunction

    // Expected output beats for one accepted input byte
    function automatic void predict_extract(input logic [7:0] b, input logic eos);
        logic printable;
        int   k;
        begin
            staged_valid = 1'b0;
            printable    = (b >= pre_pkg::PRINT_LO) && (b <= pre_pkg::PRINT_HI);
            if (printable)
            begin
                if (in_run)
                begin
                    stage_beat(b);
                end
                else if (held_count + 1 >= eff_threshold(cfg_min_len))
                begin
                    for (k = 0; k < held_count; k++)
                    begin
                        stage_beat(held_bytes[k]);
                    end
                    stage_beat(b);
                    held_count = '0;
                    in_run     = 1'b1;
                end
                else
                begin
                    held_bytes[held_count] = b;
                    held_count             = held_count + 1'b1;
                end
            end
            else
            begin
                if (in_run)
                begin
                    stage_beat(pre_pkg::NEWLINE_BYTE);
                end
                in_run     = 1'b0;
                held_count = '0;
            end
            if (eos)
            begin
                if (in_run)
                begin
                    stage_beat(pre_pkg::NEWLINE_BYTE);
                end
                in_run     = 1'b0;
                held_count = '0;
            end
            if (staged_valid)
            begin
                staged_beat.last = 1'b1;
                expected_beats.push_back(staged_beat);
            end
        end
    endfunction

    // Send one byte; returns once the beat is accepted
    task automatic send_byte(input logic [7:0] b, input logic eos);
        begin
            @(negedge clk);
            while (!steady && $urandom_range(0, 99) < IDLE_PCT)
            begin
                push = 1'b0;
                @(negedge clk);
            end
            push          = 1'b1;
            data_byte     = b;
            end_of_stream = eos;
            do
                @(posedge clk);
            while (full);
            predict_extract(b, eos);
        end
    endtask

    // Stop sending, let every expected beat arrive, then let the block settle
    task automatic wait_drained();
        begin
            @(negedge clk);
            push = 1'b0;
            while (expected_beats.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic check_min_run_length(input logic [5:0] value);
        begin
            @(negedge clk);
            psel    = 1'b1;
            pwrite  = 1'b0;
            penable = 1'b0;
            paddr   = ADDR_MIN_RUN_LENGTH;
            @(negedge clk);
            penable = 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== 32'(value))
            begin
                err_cnt++;
                $display("%0t: min_run_length read expected %h actual %h",
                         $realtime, 32'(value), prdata);
            end
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    // Register write, then read back
    task automatic write_min_run_length(input logic [5:0] value);
        begin
            @(negedge clk);
            psel    = 1'b1;
            pwrite  = 1'b1;
            penable = 1'b0;
            paddr   = ADDR_MIN_RUN_LENGTH;
            pwdata  = 32'(value);
            @(negedge clk);
            penable = 1'b1;
            do
                @(posedge clk);
            while (!pready);
            cfg_min_len = value;
            @(negedge clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
            check_min_run_length(value);
        end
    endtask

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(pre_pkg::PRINT_LO, pre_pkg::PRINT_HI));
    endfunction

    function automatic logic [7:0] rand_control();
        if ($urandom_range(0, 1) == 0)
        begin
            return 8'($urandom_range(0, pre_pkg::PRINT_LO - 1));
        end
        return 8'($urandom_range(pre_pkg::PRINT_HI + 1, 255));
    endfunction

    // Reset value, runs that flush, drop and close, end of stream cases
    task automatic test_reset_threshold();
        begin
            check_min_run_length(pre_pkg::MIN_RUN_RESET);
            send_byte(8'h41, 1'b0);
            send_byte(8'h42, 1'b0);     // reaches two: flush held byte and this one
            send_byte(8'h43, 1'b0);
            send_byte(8'h0A, 1'b0);     // control byte closes the run
            send_byte(8'h20, 1'b0);
            send_byte(8'h1F, 1'b0);     // short run dropped
            send_byte(8'h7E, 1'b0);
            send_byte(8'h7E, 1'b1);     // run emitted and closed by end of stream
            send_byte(8'hFF, 1'b1);     // nothing open at end of stream
            send_byte(8'h30, 1'b1);     // short run dropped at end of stream
            send_byte(8'h61, 1'b0);
            send_byte(8'h62, 1'b0);
            send_byte(8'h00, 1'b1);     // closed once, not twice
            wait_drained();
        end
    endtask

    // Zero threshold behaves as one
    task automatic test_zero_threshold();
        begin
            write_min_run_length(6'd0);
            send_byte(8'h20, 1'b0);
            send_byte(8'h7E, 1'b0);
            send_byte(8'h7F, 1'b0);
            send_byte(8'h80, 1'b1);
            wait_drained();
        end
    endtask

    // Threshold lowered while bytes are held: next printable byte flushes
    task automatic test_threshold_change_mid_run();
        int k;
        begin
            write_min_run_length(6'd10);
            for (k = 0; k < 5; k++)
            begin
                send_byte(8'h61 + 8'(k), 1'b0);
            end
            wait_drained();
            write_min_run_length(6'd3);
            send_byte(8'h66, 1'b0);
            send_byte(8'h7F, 1'b1);
            wait_drained();
        end
    endtask

    // Random streams over a series of thresholds, extremes included
    task automatic test_random_thresholds();
        logic [5:0]  thr_list [10];
        int          per_phase;
        int          phase;
        int          sent;
        int          run_len;
        int          t;
        int          k;
        int          sel;
        logic        eos;
        begin
            thr_list  = '{6'd3, 6'd1, 6'd32, 6'd5, 6'd63, 6'd0, 6'd2, 6'd8, 6'd33, 6'd17};
            per_phase = RANDOM_ITEMS / 10;
            for (phase = 0; phase < 10; phase++)
            begin
                write_min_run_length(thr_list[phase]);
                steady = (phase == 6);
                t      = eff_threshold(thr_list[phase]);
                sent   = 0;
                while (sent < per_phase)
                begin
                    // Run lengths cluster around the threshold
                    sel = $urandom_range(0, 9);
                    if (sel < 4)
                    begin
                        run_len = t - 1 + $urandom_range(0, 2);
                    end
                    else if (sel < 8)
                    begin
                        run_len = $urandom_range(1, t + 4);
                    end
                    else
                    begin
                        run_len = $urandom_range(0, 40);
                    end
                    for (k = 0; k < run_len && sent < per_phase; k++)
                    begin
                        eos = (k == run_len - 1) && ($urandom_range(0, 4) == 0);
                        send_byte(rand_printable(), eos);
                        sent++;
                    end
                    // Separator: control byte, sometimes ending the stream
                    if ($urandom_range(0, 9) < 8)
                    begin
                        send_byte(rand_control(), 1'($urandom_range(0, 9) == 0));
                        sent++;
                    end
                end
                wait_drained();
                steady = 1'b0;
            end
        end
    endtask

    // Result side: random pop, held high while steady
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop = steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_beats.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected beat expected none actual byte %h last %b",
                         $realtime, out_byte, last_of_burst);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (out_byte !== want.value)
                begin
                    err_cnt++;
                    $display("%0t: out_byte expected %h actual %h",
                             $realtime, want.value, out_byte);
                end
                if (last_of_burst !== want.last)
                begin
                    err_cnt++;
                    $display("%0t: last_of_burst expected %b actual %b",
                             $realtime, want.last, last_of_burst);
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        push          = 1'b0;
        data_byte     = '0;
        end_of_stream = 1'b0;
        steady        = 1'b0;
        err_cnt       = 0;
        cfg_min_len   = pre_pkg::MIN_RUN_RESET;
        held_count    = '0;
        in_run        = 1'b0;
        staged_valid  = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_threshold();
        test_zero_threshold();
        test_threshold_change_mid_run();
        test_random_thresholds();

        if (err_cnt == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
